>>> hw/rtl/query_token_lexer_core_defines.svh
// ---------------------------------------------------------------------------
// query_token_lexer_core_defines: assertion macros
// Assertion helpers shared by the lexer RTL; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef QUERY_TOKEN_LEXER_CORE_DEFINES_SVH
`define QUERY_TOKEN_LEXER_CORE_DEFINES_SVH
`ifndef SYNTH
`define QTL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define QTL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define QTL_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define QTL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/qtl_pkg.sv
// ---------------------------------------------------------------------------
// qtl_pkg: query token lexer package
// Types, codes, keyword table and character class helpers.
// ---------------------------------------------------------------------------
package qtl_pkg;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'd0,
        ST_IDENT = 4'd1,
        ST_INT   = 4'd2,
        ST_FRAC  = 4'd3,
        ST_STR   = 4'd4,
        ST_GT    = 4'd5,
        ST_LT    = 4'd6,
        ST_EQ    = 4'd7,
        ST_BANG  = 4'd8,
        ST_ERR   = 4'd9
    } t_lex_state;

    localparam logic [1:0] KIND_TEXT  = 2'd0;
    localparam logic [1:0] KIND_TOKEN = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [4:0] TT_ID    = 5'd0;
    localparam logic [4:0] TT_NUM   = 5'd1;
    localparam logic [4:0] TT_STR   = 5'd2;
    localparam logic [4:0] TT_COMMA = 5'd3;
    localparam logic [4:0] TT_STAR  = 5'd4;
    localparam logic [4:0] TT_LP    = 5'd5;
    localparam logic [4:0] TT_RP    = 5'd6;
    localparam logic [4:0] TT_GT    = 5'd7;
    localparam logic [4:0] TT_GE    = 5'd8;
    localparam logic [4:0] TT_LT    = 5'd9;
    localparam logic [4:0] TT_LE    = 5'd10;
    localparam logic [4:0] TT_EQ    = 5'd11;
    localparam logic [4:0] TT_NE    = 5'd12;
    localparam logic [4:0] TT_KW0   = 5'd13;
    localparam logic [4:0] TT_END   = 5'd24;

    localparam logic [2:0] ERR_BAD_CHAR  = 3'd0;
    localparam logic [2:0] ERR_LONE_EQ   = 3'd1;
    localparam logic [2:0] ERR_LONE_BANG = 3'd2;
    localparam logic [2:0] ERR_UNTERM    = 3'd3;
    localparam logic [2:0] ERR_STR_LONG  = 3'd4;
    localparam logic [2:0] ERR_TOKENS    = 3'd5;
    localparam logic [2:0] ERR_SIZE      = 3'd6;

    localparam logic [1:0] CFG_MAX_QUERY  = 2'd0;
    localparam logic [1:0] CFG_MAX_TOKENS = 2'd1;
    localparam logic [1:0] CFG_MAX_STRING = 2'd2;

    localparam logic [16:0] SAT17 = 17'h1FFFF;
    localparam int          NUM_KW = 11;

    // Keywords packed right-aligned, one byte per character, with lengths.
    localparam logic [47:0] KW_TEXT [NUM_KW] = '{
        48'h000066726f6d, // from
        48'h007768657265, // where
        48'h73656c656374, // select
        48'h006c696d6974, // limit
        48'h006f72646572, // order
        48'h000000006279, // by
        48'h0067726f7570, // group
        48'h000000617363, // asc
        48'h000064657363, // desc
        48'h000000616e64, // and
        48'h000000006f72  // or
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd4, 3'd5, 3'd6, 3'd5, 3'd5, 3'd2, 3'd5, 3'd3, 3'd4, 3'd3, 3'd2
    };

    typedef struct packed {
        logic [16:0] line;
        logic [16:0] col;
    } t_pos;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  ttype;
        logic [7:0]  tbyte;
        logic [16:0] line;
        logic [16:0] col;
        logic [15:0] len;
        logic [2:0]  err;
    } t_rec;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == 8'h20 || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5a) ? b + 8'd32 : b;
    endfunction

    function automatic t_pos advance(input t_pos p, input logic [7:0] b);
        t_pos q;
        q = p;
        if (b == 8'h0a) begin
            if (p.line != SAT17) q.line = p.line + 17'd1;
            q.col = 17'd1;
        end else if (p.col != SAT17) begin
            q.col = p.col + 17'd1;
        end
        return q;
    endfunction

    function automatic t_rec mk_rec(input logic [1:0] kind, input logic [4:0] ttype,
                                    input logic [7:0] tbyte, input t_pos p,
                                    input logic [15:0] len, input logic [2:0] err);
        t_rec r;
        r.kind  = kind;
        r.ttype = ttype;
        r.tbyte = tbyte;
        r.line  = p.line;
        r.col   = p.col;
        r.len   = len;
        r.err   = err;
        return r;
    endfunction

endpackage

>>> hw/rtl/query_token_lexer_core.sv
// ---------------------------------------------------------------------------
// query_token_lexer_core: streaming lexer for a small query language
// Turns query bytes into token text bytes, token records and error records.
// ---------------------------------------------------------------------------
// Usage: each input request carries one query byte (i_mode low) or an
// end-of-query marker (i_mode high) over a valid/ready channel. The lexer
// state is updated in the cycle the request is accepted and the results it
// causes, none to three, are loaded into a three-slot result buffer. The buffer
// drives the output channel one result per cycle, the last of the run
// flagged by o_last_of_run. The first result is offered in the cycle after the
// request is accepted. Throughput is one request per cycle while each request
// causes at most one result and the receiver is ready; a request with several
// results hands them over one at a time through the single output port of the
// result buffer. A new request is taken while the final result of the previous
// one is still being handed over. If the receiver stalls, the buffer holds its
// results and o_in_ready stays low while any of them waits; it rises only in a
// cycle where the final result is taken. Reset empties the buffer, returns the
// lexer to the start of a query and loads the register defaults; configuration
// writes take effect at once.
// ---------------------------------------------------------------------------
`include "query_token_lexer_core_defines.svh"

module query_token_lexer_core #(
    parameter int COUNTER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic [7:0]  i_source_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_record_kind,
    output logic [4:0]  o_token_type,
    output logic [7:0]  o_text_byte,
    output logic [16:0] o_line_number,
    output logic [16:0] o_column_number,
    output logic [15:0] o_text_length,
    output logic [2:0]  o_error_code,
    output logic        o_last_of_run
);

    localparam logic [COUNTER_BITS-1:0] TC_MAX = '1;

    // Configuration registers.
    logic [15:0] r_max_query;
    logic [15:0] r_max_tokens;
    logic [15:0] r_max_string;

    // Lexer state.
    qtl_pkg::t_lex_state     r_state, n_state;
    logic                    r_qdbl, n_qdbl;
    qtl_pkg::t_pos           r_cur, n_cur;
    qtl_pkg::t_pos           r_start, n_start;
    logic [COUNTER_BITS-1:0] r_tc, n_tc;
    logic [47:0]             r_win, n_win;
    logic [16:0]             r_tokens, n_tokens;
    logic [16:0]             r_bytes, n_bytes;

    // Result buffer.
    qtl_pkg::t_rec r_slot [3];
    logic [1:0]    r_head;
    logic [1:0]    r_left;

    qtl_pkg::t_rec c_res [3];
    logic [1:0]    c_n;
    logic          c_emit;
    logic [4:0]    c_type;
    logic [15:0]   c_len;
    logic          c_fall;
    logic          c_single;
    logic [4:0]    c_single_type;
    logic [4:0]    c_kw_type;
    logic [15:0]   c_tc_len;
    logic [7:0]    b;
    logic          in_acc;
    logic          out_acc;
    qtl_pkg::t_rec c_head;

    assign b        = i_source_byte;
    assign c_tc_len = 16'(32'(r_tc));
    assign out_acc  = o_out_valid && i_out_ready;
    // Room for a new run once the buffer is empty or its last result leaves now.
    assign o_in_ready = (r_left == 2'd0) || (r_left == 2'd1 && i_out_ready);
    assign in_acc     = i_in_valid && o_in_ready;

    // Keyword lookup on the lowercase window of the pending identifier.
    always_comb begin
        c_kw_type = qtl_pkg::TT_ID;
        for (int k = qtl_pkg::NUM_KW - 1; k >= 0; k--) begin
            if (r_tc == COUNTER_BITS'(qtl_pkg::KW_LEN[k]) && r_win == qtl_pkg::KW_TEXT[k]) begin
                c_kw_type = qtl_pkg::TT_KW0 + 5'(k);
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_qdbl   = r_qdbl;
        n_cur    = r_cur;
        n_start  = r_start;
        n_tc     = r_tc;
        n_win    = r_win;
        n_tokens = r_tokens;
        n_bytes  = r_bytes;
        c_n      = 2'd0;
        c_res    = '{default: '0};
        c_emit   = 1'b0;
        c_type   = qtl_pkg::TT_ID;
        c_len    = 16'd0;
        c_fall   = 1'b0;
        c_single = 1'b0;
        c_single_type = qtl_pkg::TT_ID;
        if (in_acc) begin
            if (i_mode) begin
                // Close whatever token is pending at end of query, or report an unterminated string or a lone = or !.
                unique case (r_state)
                    qtl_pkg::ST_IDENT: begin
                        c_emit = 1'b1; c_type = c_kw_type; c_len = c_tc_len;
                    end
                    qtl_pkg::ST_INT, qtl_pkg::ST_FRAC: begin
                        c_emit = 1'b1; c_type = qtl_pkg::TT_NUM; c_len = c_tc_len;
                    end
                    qtl_pkg::ST_STR: begin
                        c_res[c_n] = qtl_pkg::mk_rec(qtl_pkg::KIND_ERROR, 5'd0, 8'd0,
                                                     r_start, 16'd0, qtl_pkg::ERR_UNTERM);
                        c_n = c_n + 2'd1;
                        n_state = qtl_pkg::ST_ERR;
                    end
                    qtl_pkg::ST_GT: begin
                        c_emit = 1'b1; c_type = qtl_pkg::TT_GT; c_len = 16'd1;
                    end
                    qtl_pkg::ST_LT: begin
                        c_emit = 1'b1; c_type = qtl_pkg::TT_LT; c_len = 16'd1;
                    end
                    qtl_pkg::ST_EQ: begin
                        c_res[c_n] = qtl_pkg::mk_rec(qtl_pkg::KIND_ERROR, 5'd0, 8'd0,
                                                     r_start, 16'd0, qtl_pkg::ERR_LONE_EQ);
                        c_n = c_n + 2'd1;
                        n_state = qtl_pkg::ST_ERR;
                    end
                    qtl_pkg::ST_BANG: begin
                        c_res[c_n] = qtl_pkg::mk_rec(qtl_pkg::KIND_ERROR, 5'd0, 8'd0,
                                                     r_start, 16'd0, qtl_pkg::ERR_LONE_BANG);
                        c_n = c_n + 2'd1;
                        n_state = qtl_pkg::ST_ERR;
                    end
                    default: ;
                endcase
            end else if (r_state != qtl_pkg::ST_ERR) begin
                if (r_bytes != qtl_pkg::SAT17) n_bytes = r_bytes + 17'd1;
                if (n_bytes > {1'b0, r_max_query}) begin
                    c_res[c_n] = qtl_pkg::mk_rec(qtl_pkg::KIND_ERROR, 5'd0, 8'd0,
                                                 r_cur, 16'd0, qtl_pkg::ERR_SIZE);
                    c_n = c_n + 2'd1;
                    n_state = qtl_pkg::ST_ERR;
                end else begin
                    unique case (r_state)
                        qtl_pkg::ST_IDENT: begin
                            if (qtl_pkg::is_alpha(b) || qtl_pkg::is_digit(b) || b == 8'h5f ||
                                b == 8'h2e || b == 8'h2f) begin
                                c_res[c_n] = qtl_pkg::mk_rec(qtl_pkg::KIND_TEXT, 5'd0, b,
                                                             r_start, 16'd0, 3'd0);
                                c_n = c_n + 2'd1;
                                n_win = {r_win[39:0], qtl_pkg::to_lower(b)};
                                if (r_tc != TC_MAX) n_tc = r_tc + 1'b1;
                                n_cur = qtl_pkg::advance(r_cur, b);
                            end else begin
                                c_emit = 1'b1; c_type = c_kw_type; c_len = c_tc_len;
                                c_fall = 1'b1;
                            end
                        end
                        qtl_pkg::ST_INT, qtl_pkg::ST_FRAC: begin
                            if (qtl_pkg::is_digit(b) ||
                                (b == 8'h2e && r_state == qtl_pkg::ST_INT)) begin
                                c_res[c_n] = qtl_pkg::mk_rec(qtl_pkg::KIND_TEXT, 5'd0, b,
                                                             r_start, 16'd0, 3'd0);
                                c_n = c_n + 2'd1;
                                if (r_tc != TC_MAX) n_tc = r_tc + 1'b1;
                                if (b == 8'h2e) n_state = qtl_pkg::ST_FRAC;
                                n_cur = qtl_pkg::advance(r_cur, b);
                            end else begin
                                c_emit = 1'b1; c_type = qtl_pkg::TT_NUM; c_len = c_tc_len;
                                c_fall = 1'b1;
                            end
                        end
                        qtl_pkg::ST_STR: begin
                            if (b == (r_qdbl ? 8'h22 : 8'h27)) begin
                                n_cur = qtl_pkg::advance(r_cur, b);
                                c_emit = 1'b1; c_type = qtl_pkg::TT_STR; c_len = c_tc_len;
                            end else if ({1'b0, 32'(r_tc)} + 33'd1 > 33'(r_max_string)) begin
                                c_res[c_n] = qtl_pkg::mk_rec(qtl_pkg::KIND_ERROR, 5'd0, 8'd0,
                                                             r_start, 16'd0,
                                                             qtl_pkg::ERR_STR_LONG);
                                c_n = c_n + 2'd1;
                                n_state = qtl_pkg::ST_ERR;
                            end else begin
                                c_res[c_n] = qtl_pkg::mk_rec(qtl_pkg::KIND_TEXT, 5'd0, b,
                                                             r_start, 16'd0, 3'd0);
                                c_n = c_n + 2'd1;
                                if (r_tc != TC_MAX) n_tc = r_tc + 1'b1;
                                n_cur = qtl_pkg::advance(r_cur, b);
                            end
                        end
                        qtl_pkg::ST_GT, qtl_pkg::ST_LT: begin
                            if (b == 8'h3d) begin
                                c_res[c_n] = qtl_pkg::mk_rec(qtl_pkg::KIND_TEXT, 5'd0, b,
                                                             r_start, 16'd0, 3'd0);
                                c_n = c_n + 2'd1;
                                n_cur = qtl_pkg::advance(r_cur, b);
                                c_emit = 1'b1;
                                c_type = (r_state == qtl_pkg::ST_GT) ? qtl_pkg::TT_GE
                                                                     : qtl_pkg::TT_LE;
                                c_len = 16'd2;
                            end else begin
                                c_emit = 1'b1;
                                c_type = (r_state == qtl_pkg::ST_GT) ? qtl_pkg::TT_GT
                                                                     : qtl_pkg::TT_LT;
                                c_len = 16'd1;
                                c_fall = 1'b1;
                            end
                        end
                        qtl_pkg::ST_EQ, qtl_pkg::ST_BANG: begin
                            if (b == 8'h3d) begin
                                c_res[c_n] = qtl_pkg::mk_rec(qtl_pkg::KIND_TEXT, 5'd0, b,
                                                             r_start, 16'd0, 3'd0);
                                c_n = c_n + 2'd1;
                                n_cur = qtl_pkg::advance(r_cur, b);
                                c_emit = 1'b1;
                                c_type = (r_state == qtl_pkg::ST_EQ) ? qtl_pkg::TT_EQ
                                                                     : qtl_pkg::TT_NE;
                                c_len = 16'd2;
                            end else begin
                                // The byte after a lone = or ! is dropped.
                                c_res[c_n] = qtl_pkg::mk_rec(qtl_pkg::KIND_ERROR, 5'd0, 8'd0,
                                    r_start, 16'd0,
                                    (r_state == qtl_pkg::ST_EQ) ? qtl_pkg::ERR_LONE_EQ
                                                                : qtl_pkg::ERR_LONE_BANG);
                                c_n = c_n + 2'd1;
                                n_state = qtl_pkg::ST_ERR;
                            end
                        end
                        default: c_fall = 1'b1;
                    endcase
                end
            end

            // Token record for the token that just closed, or the token
            // limit error at the position reached so far.
            if (c_emit) begin
                if (n_tokens != qtl_pkg::SAT17) n_tokens = n_tokens + 17'd1;
                if (n_tokens > {1'b0, r_max_tokens}) begin
                    c_res[c_n] = qtl_pkg::mk_rec(qtl_pkg::KIND_ERROR, 5'd0, 8'd0,
                                                 n_cur, 16'd0, qtl_pkg::ERR_TOKENS);
                    n_state = qtl_pkg::ST_ERR;
                end else begin
                    c_res[c_n] = qtl_pkg::mk_rec(qtl_pkg::KIND_TOKEN, c_type, 8'd0,
                                                 n_start, c_len, 3'd0);
                    n_state = qtl_pkg::ST_IDLE;
                end
                c_n = c_n + 2'd1;
            end

            if (i_mode && r_state != qtl_pkg::ST_ERR && n_state == qtl_pkg::ST_IDLE) begin
                c_res[c_n] = qtl_pkg::mk_rec(qtl_pkg::KIND_TOKEN, qtl_pkg::TT_END, 8'd0,
                                             n_cur, 16'd0, 3'd0);
                c_n = c_n + 2'd1;
            end

            // The byte that ended a token, and any byte seen in idle, is lexed from idle.
            if (c_fall && n_state == qtl_pkg::ST_IDLE) begin
                if (qtl_pkg::is_space(b)) begin
                    n_cur = qtl_pkg::advance(n_cur, b);
                end else begin
                    n_start = n_cur;
                    n_tc    = '0;
                    n_win   = 48'd0;
                    priority if (qtl_pkg::is_alpha(b) || b == 8'h5f) begin
                        c_res[c_n] = qtl_pkg::mk_rec(qtl_pkg::KIND_TEXT, 5'd0, b,
                                                     n_start, 16'd0, 3'd0);
                        c_n = c_n + 2'd1;
                        n_win   = {40'd0, qtl_pkg::to_lower(b)};
                        n_tc    = COUNTER_BITS'(1);
                        n_state = qtl_pkg::ST_IDENT;
                        n_cur   = qtl_pkg::advance(n_cur, b);
                    end else if (qtl_pkg::is_digit(b)) begin
                        c_res[c_n] = qtl_pkg::mk_rec(qtl_pkg::KIND_TEXT, 5'd0, b,
                                                     n_start, 16'd0, 3'd0);
                        c_n = c_n + 2'd1;
                        n_tc    = COUNTER_BITS'(1);
                        n_state = qtl_pkg::ST_INT;
                        n_cur   = qtl_pkg::advance(n_cur, b);
                    end else if (b == 8'h22 || b == 8'h27) begin
                        n_qdbl  = (b == 8'h22);
                        n_state = qtl_pkg::ST_STR;
                        n_cur   = qtl_pkg::advance(n_cur, b);
                    end else if (b == 8'h2c || b == 8'h2a || b == 8'h28 || b == 8'h29 ||
                                 b == 8'h3e || b == 8'h3c || b == 8'h3d || b == 8'h21) begin
                        c_res[c_n] = qtl_pkg::mk_rec(qtl_pkg::KIND_TEXT, 5'd0, b,
                                                     n_start, 16'd0, 3'd0);
                        c_n = c_n + 2'd1;
                        n_cur = qtl_pkg::advance(n_cur, b);
                        unique case (b)
                            8'h2c: begin c_single = 1'b1; c_single_type = qtl_pkg::TT_COMMA; end
                            8'h2a: begin c_single = 1'b1; c_single_type = qtl_pkg::TT_STAR; end
                            8'h28: begin c_single = 1'b1; c_single_type = qtl_pkg::TT_LP; end
                            8'h29: begin c_single = 1'b1; c_single_type = qtl_pkg::TT_RP; end
                            8'h3e: n_state = qtl_pkg::ST_GT;
                            8'h3c: n_state = qtl_pkg::ST_LT;
                            8'h3d: n_state = qtl_pkg::ST_EQ;
                            default: n_state = qtl_pkg::ST_BANG;
                        endcase
                        if (c_single) begin
                            if (n_tokens != qtl_pkg::SAT17) n_tokens = n_tokens + 17'd1;
                            if (n_tokens > {1'b0, r_max_tokens}) begin
                                c_res[c_n] = qtl_pkg::mk_rec(qtl_pkg::KIND_ERROR, 5'd0, 8'd0,
                                                             n_cur, 16'd0, qtl_pkg::ERR_TOKENS);
                                n_state = qtl_pkg::ST_ERR;
                            end else begin
                                c_res[c_n] = qtl_pkg::mk_rec(qtl_pkg::KIND_TOKEN, c_single_type,
                                                             8'd0, n_start, 16'd1, 3'd0);
                            end
                            c_n = c_n + 2'd1;
                        end
                    end else begin
                        c_res[c_n] = qtl_pkg::mk_rec(qtl_pkg::KIND_ERROR, 5'd0, 8'd0,
                                                     n_cur, 16'd0, qtl_pkg::ERR_BAD_CHAR);
                        c_n = c_n + 2'd1;
                        n_state = qtl_pkg::ST_ERR;
                    end
                end
            end

            // End of query starts a fresh query in every case.
            if (i_mode) begin
                n_state  = qtl_pkg::ST_IDLE;
                n_qdbl   = 1'b0;
                n_cur    = '{line: 17'd1, col: 17'd1};
                n_start  = '{line: 17'd1, col: 17'd1};
                n_tc     = '0;
                n_win    = 48'd0;
                n_tokens = 17'd0;
                n_bytes  = 17'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_query  <= 16'd4096;
            r_max_tokens <= 16'd1024;
            r_max_string <= 16'd255;
            r_state      <= qtl_pkg::ST_IDLE;
            r_qdbl       <= 1'b0;
            r_cur        <= '{line: 17'd1, col: 17'd1};
            r_start      <= '{line: 17'd1, col: 17'd1};
            r_tc         <= '0;
            r_win        <= 48'd0;
            r_tokens     <= 17'd0;
            r_bytes      <= 17'd0;
            r_head       <= 2'd0;
            r_left       <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    qtl_pkg::CFG_MAX_QUERY:  r_max_query  <= i_cfg_data;
                    qtl_pkg::CFG_MAX_TOKENS: r_max_tokens <= i_cfg_data;
                    qtl_pkg::CFG_MAX_STRING: r_max_string <= i_cfg_data;
                    default: ;
                endcase
            end
            r_state  <= n_state;
            r_qdbl   <= n_qdbl;
            r_cur    <= n_cur;
            r_start  <= n_start;
            r_tc     <= n_tc;
            r_win    <= n_win;
            r_tokens <= n_tokens;
            r_bytes  <= n_bytes;
            if (in_acc) begin
                r_head <= 2'd0;
                r_left <= c_n;
            end else if (out_acc) begin
                r_head <= r_head + 2'd1;
                r_left <= r_left - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_slot <= c_res;
        end
    end

    assign c_head          = r_slot[r_head];
    assign o_out_valid     = (r_left != 2'd0);
    assign o_record_kind   = c_head.kind;
    assign o_token_type    = c_head.ttype;
    assign o_text_byte     = c_head.tbyte;
    assign o_line_number   = c_head.line;
    assign o_column_number = c_head.col;
    assign o_text_length   = c_head.len;
    assign o_error_code    = c_head.err;
    assign o_last_of_run   = (r_left == 2'd1);

    `QTL_ASSERT_NEXT(a_run_shows, i_clk, i_rst_n, in_acc && c_n != 2'd0, o_out_valid)
    `QTL_ASSERT_NEXT(a_err_silent, i_clk, i_rst_n, in_acc && !i_mode && r_state == qtl_pkg::ST_ERR, !o_out_valid)
    `QTL_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(r_left) && $stable(r_head))
    `QTL_ASSERT_SAME(a_no_overrun, i_clk, i_rst_n, in_acc, r_left == 2'd0 || out_acc)

endmodule
